// File: sv/dsf_pkg.sv
`timescale 1ns / 1ps
// Package for the date span fee core: field widths, calendar constants,
// register indexes and the small arithmetic helpers. No dependencies.
package dsf_pkg;

  // Field widths.
  localparam int unsigned DayW    = 5;
  localparam int unsigned MonW    = 4;
  localparam int unsigned YearW   = 14;
  localparam int unsigned SpanW   = 22;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned FeeW    = 38;
  localparam int unsigned CumW    = 9;

  // Calendar constants.
  localparam logic [YearW-1:0] YearMax     = 14'd9999;
  localparam logic [SpanW-1:0] DaysPerYear = 22'd365;
  localparam logic [MonW-1:0]  MonthsMax   = 4'd12;
  localparam logic [MonW-1:0]  LeapMonIdx  = 4'd2;

  // Reciprocal of 25 as 5243 / 2^17; exact for the operand range used here.
  localparam logic [25:0] Recip25 = 26'd5243;
  localparam int unsigned Recip25Sh = 17;

  // Register indexes on the configuration port.
  localparam logic CfgFreeDays  = 1'b0;
  localparam logic CfgRateCents = 1'b1;

  // Register reset values (3.50 per day is held as 350 cents).
  localparam logic [CfgW-1:0] FreeDaysRst  = 16'd2;
  localparam logic [CfgW-1:0] RateCentsRst = 16'd350;

  // Floor division by 25 of a 13-bit value through a constant multiply.
  function automatic logic [8:0] div25(input logic [12:0] q);
    logic [25:0] prod;
    prod = 26'(q) * Recip25;
    return prod[Recip25Sh +: 9];
  endfunction

  // Days of a common year before the first day of month index n (0..12).
  function automatic logic [CumW-1:0] cum_days(input logic [MonW-1:0] n);
    logic [CumW-1:0] r;
    unique case (n)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      4'd12:   r = 9'd365;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// File: sv/date_span_fee_core.sv
`timescale 1ns / 1ps
// Date span fee core: day count between two Gregorian dates and a fee.
// Depends on dsf_pkg for widths, calendar constants and helpers.
//
//  Channel   Ports                                     Handshake
//  --------  ----------------------------------------  ---------------------------
//  command   start_i, busy_o, first_*_i, second_*_i    taken when start_i && !busy_o
//  result    done_o, day_span_o, fee_due_o, fee_cents_o one-cycle strobe on done_o
//  config    cfg_we_i, cfg_idx_i, cfg_wdata_i          written when cfg_we_i
//
// A new transaction is taken in every cycle; busy_o is always low.
// done_o rises with each result, which passes through five register stages: input
// capture, year terms, day numbers, span and chargeable days, and the fee multiply.
// Reset clears the stage valid bits and loads free_days = 2, rate_cents = 350.
// The receiver cannot stall, so each result leaves in the order it was taken.
module date_span_fee_core
  import dsf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [DayW-1:0]  first_day_i,
  input  logic [MonW-1:0]  first_month_i,
  input  logic [YearW-1:0] first_year_i,
  input  logic [DayW-1:0]  second_day_i,
  input  logic [MonW-1:0]  second_month_i,
  input  logic [YearW-1:0] second_year_i,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CfgW-1:0]  cfg_wdata_i,
  output logic             done_o,
  output logic [SpanW-1:0] day_span_o,
  output logic             fee_due_o,
  output logic [FeeW-1:0]  fee_cents_o
);

  // Configuration registers.
  logic [CfgW-1:0] free_days_q, rate_cents_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_days_q  <= FreeDaysRst;
      rate_cents_q <= RateCentsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgFreeDays:  free_days_q  <= cfg_wdata_i;
        CfgRateCents: rate_cents_q <= cfg_wdata_i;
        default:      free_days_q  <= free_days_q;
      endcase
    end
  end

  // The pipeline never holds off a transaction.
  assign busy_o = 1'b0;

  // Stage valid bits.
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start_i && !busy_o;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  // Per-date inputs gathered for the two identical date paths.
  logic [DayW-1:0]  in_day   [2];
  logic [MonW-1:0]  in_mon   [2];
  logic [YearW-1:0] in_year  [2];
  logic [SpanW-1:0] dnum_q   [2];

  assign in_day[0]  = first_day_i;
  assign in_mon[0]  = first_month_i;
  assign in_year[0] = first_year_i;
  assign in_day[1]  = second_day_i;
  assign in_mon[1]  = second_month_i;
  assign in_year[1] = second_year_i;

  for (genvar g = 0; g < 2; g++) begin : g_date
    logic [DayW-1:0]  day_q;
    logic [MonW-1:0]  mon_q;
    logic [YearW-1:0] year_q;

    // Stage 1: capture the date of an accepted transaction.
    always_ff @(posedge clk_i) begin
      if (start_i && !busy_o) begin
        day_q  <= in_day[g];
        mon_q  <= in_mon[g];
        year_q <= in_year[g];
      end
    end

    // Year terms: saturate, 365*y and the leap counts over [0, y).
    logic [YearW-1:0] ysat;
    logic [YearW:0]   y99, y399;
    logic [MonW-1:0]  nmon;
    logic [8:0]       div100a, div400a, div100y;

    always_comb begin
      ysat    = (year_q > YearMax) ? YearMax : year_q;
      y99     = {1'b0, ysat} + 15'd99;
      y399    = {1'b0, ysat} + 15'd399;
      div100a = div25(y99[14:2]);
      div400a = div25({2'b00, y399[14:4]});
      div100y = div25({1'b0, ysat[13:2]});
      if (mon_q == '0) begin
        nmon = '0;
      end else if (mon_q > MonthsMax) begin
        nmon = MonthsMax;
      end else begin
        nmon = mon_q - 4'd1;
      end
    end

    logic [SpanW-1:0] ybase_q;
    logic [YearW-1:0] ysat_q;
    logic [11:0]      q4a_q;
    logic [6:0]       d100a_q, q100_q;
    logic [4:0]       d400a_q;
    logic [MonW-1:0]  nmon_q;
    logic [DayW-1:0]  day2_q;

    // Stage 2 registers.
    always_ff @(posedge clk_i) begin
      ybase_q <= SpanW'(ysat) * DaysPerYear;
      ysat_q  <= ysat;
      q4a_q   <= 12'((({1'b0, ysat} + 15'd3) >> 2));
      d100a_q <= div100a[6:0];
      d400a_q <= div400a[4:0];
      q100_q  <= div100y[6:0];
      nmon_q  <= nmon;
      day2_q  <= day_q;
    end

    // Leap test of the date's own year, then the full day number.
    logic             c100, leap;
    logic [SpanW-1:0] dnum;

    always_comb begin
      c100 = (ysat_q == (14'(q100_q) * 14'd100));
      leap = (ysat_q[1:0] == 2'b00) && (!c100 || (q100_q[1:0] == 2'b00));
      dnum = ybase_q + SpanW'(q4a_q) - SpanW'(d100a_q) + SpanW'(d400a_q)
           + SpanW'(cum_days(nmon_q))
           + SpanW'(leap && (nmon_q >= LeapMonIdx))
           + SpanW'(day2_q);
    end

    // Stage 3 register.
    always_ff @(posedge clk_i) begin
      dnum_q[g] <= dnum;
    end
  end

  // Absolute span and the chargeable day count.
  logic [SpanW-1:0] span, charge;
  logic             due;

  always_comb begin
    span   = (dnum_q[0] > dnum_q[1]) ? dnum_q[0] - dnum_q[1] : dnum_q[1] - dnum_q[0];
    due    = span > SpanW'(free_days_q);
    charge = due ? span - SpanW'(free_days_q) : '0;
  end

  logic [SpanW-1:0] span_q, charge_q;
  logic             due_q;

  // Stage 4 registers.
  always_ff @(posedge clk_i) begin
    span_q   <= span;
    due_q    <= due;
    charge_q <= charge;
  end

  // Output register: fee multiply and the result strobe.
  always_ff @(posedge clk_i) begin
    day_span_o  <= span_q;
    fee_due_o   <= due_q;
    fee_cents_o <= FeeW'(charge_q) * FeeW'(rate_cents_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= s4_vld_q;
    end
  end

`ifndef SYNTHESIS
  // A result follows every accepted transaction.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##5 done_o)
    else $error("result strobe missing after accepted transaction");

  // No fee is reported unless a fee is due.
  a_fee_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !fee_due_o) |-> (fee_cents_o == '0))
    else $error("fee reported while none is due");

  // A due fee implies a nonzero span.
  a_span_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && fee_due_o) |-> (day_span_o != '0))
    else $error("fee due on an empty span");

  // Every strobe traces back to an accepted transaction.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_o) |-> $past(start_i && !busy_o, 5))
    else $error("result strobe without a transaction");
`endif

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for date_span_fee_core: directed calendar cases,
// register extremes, fee thresholds and random traffic against a local predictor.
// Depends on dsf_pkg and date_span_fee_core.
module testbench
  import dsf_pkg::*;
;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PIPE_SLACK  = 8;
  localparam logic [63:0] YEAR_CAP    = 64'd9999;

  typedef struct packed {
    logic [DayW-1:0]  first_day;
    logic [MonW-1:0]  first_month;
    logic [YearW-1:0] first_year;
    logic [DayW-1:0]  second_day;
    logic [MonW-1:0]  second_month;
    logic [YearW-1:0] second_year;
  } date_pair_t;

  typedef struct packed {
    logic [SpanW-1:0] day_span;
    logic             fee_due;
    logic [FeeW-1:0]  fee_cents;
  } span_fee_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start_i;
  logic             busy_o;
  logic [DayW-1:0]  first_day_i;
  logic [MonW-1:0]  first_month_i;
  logic [YearW-1:0] first_year_i;
  logic [DayW-1:0]  second_day_i;
  logic [MonW-1:0]  second_month_i;
  logic [YearW-1:0] second_year_i;
  logic             cfg_we_i;
  logic             cfg_idx_i;
  logic [CfgW-1:0]  cfg_wdata_i;
  logic             done_o;
  logic [SpanW-1:0] day_span_o;
  logic             fee_due_o;
  logic [FeeW-1:0]  fee_cents_o;

  // Local copy of the fee registers, updated on every write.
  logic [CfgW-1:0] free_days_now;
  logic [CfgW-1:0] rate_cents_now;

  span_fee_t   pending_fees[$];
  int unsigned error_count;
  int unsigned quiet_run;

  date_span_fee_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .first_day_i   (first_day_i),
    .first_month_i (first_month_i),
    .first_year_i  (first_year_i),
    .second_day_i  (second_day_i),
    .second_month_i(second_month_i),
    .second_year_i (second_year_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_o        (done_o),
    .day_span_o    (day_span_o),
    .fee_due_o     (fee_due_o),
    .fee_cents_o   (fee_cents_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Calendar arithmetic for the expected results.
  function automatic bit is_leap_year(input logic [63:0] yr);
    if (yr % 100 == 0) begin
      return (yr % 400) == 0;
    end
    return (yr % 4) == 0;
  endfunction

  function automatic int unsigned month_length(input int unsigned idx, input bit leap);
    case (idx)
      1: begin
        return leap ? 29 : 28;
      end
      3, 5, 8, 10: begin
        return 30;
      end
      default: begin
        return 31;
      end
    endcase
  endfunction

  // Days from the start of year 0 up to and including the given date.
  function automatic logic [63:0] day_ordinal(input logic [DayW-1:0] d,
                                              input logic [MonW-1:0] m,
                                              input logic [YearW-1:0] y);
    logic [63:0] yr;
    logic [63:0] total;
    int unsigned months_before;
    bit leap;
    yr = (64'(y) > YEAR_CAP) ? YEAR_CAP : 64'(y);
    leap = is_leap_year(yr);
    // Whole years before this one; the leap count covers years 0 .. yr-1.
    total = 64'd365 * yr + (yr + 3) / 4 - (yr + 99) / 100 + (yr + 399) / 400;
    // Month zero has no months before it; anything past December counts all twelve.
    months_before = (m == '0) ? 0 : int'(m) - 1;
    if (months_before > 12) begin
      months_before = 12;
    end
    for (int i = 0; i < months_before; i++) begin
      total += month_length(i, leap);
    end
    return total + 64'(d);
  endfunction

  function automatic span_fee_t predict_span_fee(input date_pair_t dp);
    span_fee_t want;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] span_full;
    logic [63:0] fee_full;
    a = day_ordinal(dp.first_day, dp.first_month, dp.first_year);
    b = day_ordinal(dp.second_day, dp.second_month, dp.second_year);
    span_full = (a > b) ? a - b : b - a;
    want.day_span = span_full[SpanW-1:0];
    want.fee_due = 1'b0;
    want.fee_cents = '0;
    if (64'(want.day_span) > 64'(free_days_now)) begin
      fee_full = (64'(want.day_span) - 64'(free_days_now)) * 64'(rate_cents_now);
      want.fee_due = 1'b1;
      want.fee_cents = fee_full[FeeW-1:0];
    end
    return want;
  endfunction

  function automatic date_pair_t make_pair(input int unsigned d1, input int unsigned m1,
                                           input int unsigned y1, input int unsigned d2,
                                           input int unsigned m2, input int unsigned y2);
    date_pair_t dp;
    dp.first_day    = DayW'(d1);
    dp.first_month  = MonW'(m1);
    dp.first_year   = YearW'(y1);
    dp.second_day   = DayW'(d2);
    dp.second_month = MonW'(m2);
    dp.second_year  = YearW'(y2);
    return dp;
  endfunction

  // Years around the leap rule boundaries and the saturation point.
  function automatic int unsigned pick_edge_year();
    case ($urandom_range(0, 12))
      0:       return 0;
      1:       return 1;
      2:       return 4;
      3:       return 99;
      4:       return 100;
      5:       return 399;
      6:       return 400;
      7:       return 1900;
      8:       return 2000;
      9:       return 9998;
      10:      return 9999;
      11:      return 10000;
      default: return 16383;
    endcase
  endfunction

  // Mostly plausible dates, some close pairs, raw bit patterns and boundary years.
  function automatic date_pair_t random_date_pair();
    int unsigned pick;
    int unsigned y1;
    int unsigned y2;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      return make_pair($urandom_range(1, 31), $urandom_range(1, 12), $urandom_range(1, 9999),
                       $urandom_range(1, 31), $urandom_range(1, 12), $urandom_range(1, 9999));
    end else if (pick < 70) begin
      y1 = $urandom_range(1, 9998);
      y2 = y1 + $urandom_range(0, 1);
      return make_pair($urandom_range(1, 28), $urandom_range(1, 12), y1,
                       $urandom_range(1, 31), $urandom_range(1, 12), y2);
    end else if (pick < 90) begin
      return make_pair($urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 16383),
                       $urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 16383));
    end
    y1 = pick_edge_year();
    y2 = pick_edge_year();
    return make_pair($urandom_range(0, 31), $urandom_range(0, 13), y1,
                     $urandom_range(0, 31), $urandom_range(0, 13), y2);
  endfunction

  task automatic note_failure(input string what);
    error_count++;
    if (error_count <= 10) begin
      $display("ERROR at %0t ns: %s", $time, what);
    end
  endtask

  // Sends one date pair after a random gap; returns right after the accepting edge.
  task automatic send_dates(input date_pair_t dp);
    int unsigned gap;
    if (quiet_run > 0) begin
      quiet_run--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 11);
      if ($urandom_range(0, 19) == 0) begin
        quiet_run = $urandom_range(8, 40);
      end
    end
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i        <= 1'b1;
    first_day_i    <= dp.first_day;
    first_month_i  <= dp.first_month;
    first_year_i   <= dp.first_year;
    second_day_i   <= dp.second_day;
    second_month_i <= dp.second_month;
    second_year_i  <= dp.second_year;
    do begin
      @(posedge clk_i);
    end while (busy_o !== 1'b0);
    pending_fees.push_back(predict_span_fee(dp));
  endtask

  // Stops sending and waits until every transaction has returned its result.
  task automatic drain_results();
    start_i <= 1'b0;
    while (pending_fees.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (PIPE_SLACK) @(posedge clk_i);
  endtask

  // Writes both fee registers once the core is idle.
  task automatic set_fee_terms(input logic [CfgW-1:0] free_days, input logic [CfgW-1:0] rate);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgFreeDays;
    cfg_wdata_i <= free_days;
    @(posedge clk_i);
    cfg_idx_i   <= CfgRateCents;
    cfg_wdata_i <= rate;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    free_days_now  = free_days;
    rate_cents_now = rate;
  endtask

  // Calendar corner cases under the reset fee terms.
  task automatic test_directed_calendar();
    send_dates(make_pair(15, 6, 2024, 15, 6, 2024));      // identical dates
    send_dates(make_pair(1, 1, 1, 31, 12, 9999));         // widest valid span
    send_dates(make_pair(31, 12, 9999, 1, 1, 1));         // same, reversed order
    send_dates(make_pair(28, 2, 2000, 1, 3, 2000));       // leap by the 400 rule
    send_dates(make_pair(28, 2, 1900, 1, 3, 1900));       // century, not leap
    send_dates(make_pair(28, 2, 2024, 1, 3, 2024));
    send_dates(make_pair(1, 3, 2023, 28, 2, 2023));
    send_dates(make_pair(31, 2, 2023, 3, 3, 2023));       // unchecked 31 February
    send_dates(make_pair(0, 5, 2020, 1, 5, 2020));        // day zero
    send_dates(make_pair(10, 0, 2020, 10, 1, 2020));      // month zero acts as January
    send_dates(make_pair(1, 13, 2020, 1, 1, 2021));       // month past December
    send_dates(make_pair(31, 15, 2020, 0, 14, 2021));
    send_dates(make_pair(1, 1, 0, 1, 1, 1));              // year zero is leap
    send_dates(make_pair(1, 3, 0, 1, 3, 1));
    send_dates(make_pair(1, 1, 10000, 1, 1, 9999));       // year saturation
    send_dates(make_pair(31, 15, 16383, 0, 0, 0));        // all field extremes
    send_dates(make_pair(0, 0, 0, 0, 0, 0));
    send_dates(make_pair(31, 15, 16383, 31, 15, 16383));
    send_dates(make_pair(1, 1, 2020, 3, 1, 2020));        // span equal to free days
    send_dates(make_pair(1, 1, 2020, 4, 1, 2020));        // one chargeable day
    send_dates(make_pair(29, 2, 2400, 1, 3, 2100));
  endtask

  // Zero and all-ones register values, including the largest fee.
  task automatic test_register_extremes();
    set_fee_terms('0, '0);
    send_dates(make_pair(1, 1, 2000, 1, 1, 2001));
    send_dates(make_pair(5, 5, 1555, 5, 5, 1555));
    set_fee_terms('0, '1);
    send_dates(make_pair(1, 1, 1, 31, 12, 9999));
    send_dates(make_pair(0, 0, 0, 31, 15, 16383));
    send_dates(make_pair(1, 1, 2000, 2, 1, 2000));
    set_fee_terms('1, '1);
    send_dates(make_pair(1, 1, 1, 31, 12, 9999));
    send_dates(make_pair(1, 1, 1900, 1, 1, 2000));
    set_fee_terms('1, '0);
    send_dates(make_pair(1, 1, 1, 31, 12, 9999));
  endtask

  // Free days set just below, at and just above the span of a known pair.
  task automatic test_fee_threshold();
    date_pair_t dp;
    logic [CfgW-1:0] span16;
    int unsigned y1;
    for (int n = 0; n < 4; n++) begin
      y1 = $urandom_range(1, 9800);
      dp = make_pair($urandom_range(1, 31), $urandom_range(1, 12), y1,
                     $urandom_range(1, 31), $urandom_range(1, 12), y1 + $urandom_range(0, 170));
      span16 = CfgW'(predict_span_fee(dp).day_span);
      if (predict_span_fee(dp).day_span > 22'(16'hFFFE) || span16 == '0) begin
        dp = make_pair(1, 1, 2000, 5, 2, 2001);
      end
      set_fee_terms(CfgW'(predict_span_fee(dp).day_span), CfgW'($urandom_range(0, 65535)));
      send_dates(dp);
      set_fee_terms(CfgW'(predict_span_fee(dp).day_span) - 16'd1, rate_cents_now);
      send_dates(dp);
      set_fee_terms(CfgW'(predict_span_fee(dp).day_span) + 16'd1, rate_cents_now);
      send_dates(dp);
    end
  endtask

  // Random pairs over several register settings, with a full pause mid-phase.
  task automatic test_random_traffic();
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       set_fee_terms(FreeDaysRst, RateCentsRst);
        1:       set_fee_terms('0, '1);
        2:       set_fee_terms('1, '1);
        3:       set_fee_terms(CfgW'($urandom), CfgW'($urandom));
        default: set_fee_terms(CfgW'($urandom_range(0, 40)), CfgW'($urandom));
      endcase
      for (int n = 0; n < 140; n++) begin
        if (n == 70) begin
          drain_results();
        end
        send_dates(random_date_pair());
      end
    end
  endtask

  // Compares every result with the oldest outstanding expectation.
  always @(posedge clk_i) begin : check_results
    span_fee_t want;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (pending_fees.size() == 0) begin
        note_failure($sformatf("result with nothing expected: span %0d due %0d fee %0d",
                               day_span_o, fee_due_o, fee_cents_o));
      end else begin
        want = pending_fees.pop_front();
        if (day_span_o !== want.day_span) begin
          note_failure($sformatf("day_span expected %0d, got %0d", want.day_span, day_span_o));
        end
        if (fee_due_o !== want.fee_due) begin
          note_failure($sformatf("fee_due expected %0d, got %0d", want.fee_due, fee_due_o));
        end
        if (fee_cents_o !== want.fee_cents) begin
          note_failure($sformatf("fee_cents expected %0d, got %0d", want.fee_cents,
                                 fee_cents_o));
        end
      end
    end
  end

  // Watchdog against a hung handshake or missing results.
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("date_span_fee_core regression: fail");
    $finish;
  end

  // Test sequence.
  initial begin : run_tests
    error_count    = 0;
    quiet_run      = 0;
    free_days_now  = FreeDaysRst;
    rate_cents_now = RateCentsRst;
    rst_ni         <= 1'b0;
    start_i        <= 1'b0;
    first_day_i    <= '0;
    first_month_i  <= '0;
    first_year_i   <= '0;
    second_day_i   <= '0;
    second_month_i <= '0;
    second_year_i  <= '0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= CfgFreeDays;
    cfg_wdata_i    <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_calendar();
    test_register_extremes();
    test_fee_threshold();
    test_random_traffic();
    drain_results();
    if (error_count == 0) begin
      $display("date_span_fee_core regression: pass");
    end else begin
      $display("date_span_fee_core regression: fail");
    end
    $finish;
  end

endmodule
